// ===== design/sem_pkg.sv =====
// Package for the Sobel edge magnitude block: widths, register indexes, kernels,
// the pixel type and the gradient function. No dependencies.
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int NUM_CH     = 3;
  localparam int CH_W       = 8;
  localparam int IN_DATA_W  = NUM_CH * CH_W;
  localparam int OUT_DATA_W = NUM_CH * CH_W;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0]     WIDTH_RESET      = 11'd640;
  localparam logic [CFG_W-1:0]     HEIGHT_RESET     = 11'd480;

  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 22;
  localparam int ROOT_W     = 11;
  localparam int REM_W      = 14;
  localparam int ROOT_STEPS = 11;
  localparam int STEP_W     = 4;
  localparam logic [CH_W-1:0] SAT_MAX = 8'd255;

  localparam int KX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int KY [3][3] = '{'{-1, -2, -1}, '{0, 0, 0}, '{1, 2, 1}};

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;
  typedef logic [2:0][2:0][CH_W-1:0]   lane_win_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } grad_t;

  // The window is indexed [column][row], column 0 on the left, row 0 on top.
  function automatic grad_t sobel_grad(input lane_win_t v);
    int    sx;
    int    sy;
    grad_t g;
    sx = 0;
    sy = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sx = sx + int'(v[c][r]) * KX[r][c];
        sy = sy + int'(v[c][r]) * KY[r][c];
      end
    end
    g.gx = GRAD_W'(sx);
    g.gy = GRAD_W'(sy);
    return g;
  endfunction

endpackage

// ===== design/sobel_edge_magnitude.sv =====
// Sobel 3x3 edge magnitude over a raster RGB stream, one line memory and a window.
// Depends on sem_pkg.
//
//   Channel  Dir  Handshake            Payload
//   in       in   in_tvalid/in_tready  in_tdata (red, green, blue), in_tuser (operation)
//   out      out  out_tvalid/out_tready out_tdata (red, green, blue), out_tlast (frame_end)
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// An item that yields a pixel runs through the read, squaring, 11-step square root
// and done states; the root unit works on all three channels at once. An item that
// yields no pixel passes through the read state only; an ignored flush stays in idle.
// A result waits in the output register while the next item is taken in.
// Reset is synchronous; the line memory needs no clearing pass.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sem_pkg::IN_DATA_W-1:0]   in_tdata,   // red_in, green_in, blue_in
  input  logic                            in_tuser,   // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sem_pkg::OUT_DATA_W-1:0]  out_tdata,  // red_out, green_out, blue_out
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sem_pkg::CFG_W-1:0]       cfg_data
);
  import sem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int EW = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int PW = CW + HW;
  localparam int LW = 2 * IN_DATA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_SQR  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [EW-1:0]    emit_cnt_r, emit_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] step_r;

  logic [EW-1:0]    total_r;
  logic [CW-1:0]    cur_col_r;
  logic             item_flush_r;
  pixel_t           item_pix_r;
  logic [LW-1:0]    rd_r;
  pixel_t           win_r [2][3];
  grad_t            grad_r [NUM_CH];
  logic [SQ_W-1:0]  rad_r  [NUM_CH];
  logic [REM_W-1:0] rem_r  [NUM_CH];
  logic [ROOT_W-1:0] root_r [NUM_CH];
  pixel_t           out_pix_r;
  logic             out_last_r;

  logic [LW-1:0]    line_mem [MAX_WIDTH];

  logic [CW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [PW-1:0]    prod;
  logic [CW-1:0]    c_eff;
  logic [CW-1:0]    c_inc;
  logic             in_acc;
  logic             drop;
  logic             cfg_restart;
  logic             out_free;
  logic             frame_last;
  logic             emit;
  logic             left_ok;
  pixel_t           fresh [3];
  pixel_t           cols [3][3];
  lane_win_t        lane_win [NUM_CH];
  grad_t            grad_nxt [NUM_CH];
  logic [REM_W-1:0] rem_sh [NUM_CH];
  logic [REM_W-1:0] trial [NUM_CH];
  logic [ROOT_W:0]  rounded [NUM_CH];
  pixel_t           mag;

  always_comb begin
    if (width_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  assign prod        = PW'(w_eff) * PW'(h_eff);
  assign c_eff       = (32'(col_r) >= 32'(w_eff)) ? '0 : col_r;
  assign in_tready   = (state_r == S_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign drop        = in_tuser && (row_r == '0) && (c_eff == '0);
  assign cfg_restart = cfg_we && ((cfg_index == REG_FRAME_WIDTH) ||
                                  (cfg_index == REG_FRAME_HEIGHT));
  assign out_free    = !out_valid_r || out_tready;
  assign frame_last  = (32'(emit_cnt_r) + 1 >= 32'(total_r));
  assign c_inc       = cur_col_r + CW'(1);

  // Column assembly and gradients for the item whose line data just arrived.
  always_comb begin
    fresh[0] = ((32'(row_r) >= 2) && (32'(row_r) < 32'(h_eff) + 2)) ?
               pixel_t'(rd_r[LW-1:IN_DATA_W]) : '0;
    fresh[1] = ((32'(row_r) >= 1) && (32'(row_r) < 32'(h_eff) + 1)) ?
               pixel_t'(rd_r[IN_DATA_W-1:0]) : '0;
    fresh[2] = (!item_flush_r && (32'(row_r) < 32'(h_eff))) ? item_pix_r : '0;
    emit     = (cur_col_r == '0) ? (32'(row_r) >= 2) : (row_r != '0);
    left_ok  = (cur_col_r == '0) ? (32'(w_eff) >= 2) : (32'(cur_col_r) >= 2);
    for (int k = 0; k < 3; k++) begin
      cols[0][k] = left_ok ? win_r[0][k] : '0;
      cols[1][k] = win_r[1][k];
      cols[2][k] = (cur_col_r != '0) ? fresh[k] : '0;
    end
    for (int l = 0; l < NUM_CH; l++) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          lane_win[l][c][r] = cols[c][r][l];
        end
      end
      grad_nxt[l] = sobel_grad(lane_win[l]);
    end
  end

  // One digit-pair step of the restoring square root, and the final rounding and saturation.
  always_comb begin
    for (int l = 0; l < NUM_CH; l++) begin
      rem_sh[l]  = {rem_r[l][REM_W-3:0], rad_r[l][SQ_W-1:SQ_W-2]};
      trial[l]   = REM_W'({root_r[l], 2'b01});
      rounded[l] = {1'b0, root_r[l]} +
                   ((rem_r[l] > REM_W'(root_r[l])) ? (ROOT_W+1)'(1) : '0);
      mag[l]     = (32'(rounded[l]) > 32'(SAT_MAX)) ? SAT_MAX : rounded[l][CH_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    emit_cnt_nxt  = emit_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_acc && !drop) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (32'(c_inc) >= 32'(w_eff)) begin
          col_nxt = '0;
          row_nxt = row_r + RW'(1);
        end else begin
          col_nxt = c_inc;
        end
        state_nxt = emit ? S_SQR : S_IDLE;
      end
      S_SQR: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (step_r == STEP_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (frame_last) begin
            col_nxt      = '0;
            row_nxt      = '0;
            emit_cnt_nxt = '0;
          end else begin
            emit_cnt_nxt = emit_cnt_r + EW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
    if (cfg_restart) begin
      col_nxt      = '0;
      row_nxt      = '0;
      emit_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= WIDTH_RESET;
      height_r    <= HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      emit_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_ROOT) begin
        step_r <= step_r + STEP_W'(1);
      end else begin
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_restart || (state_r == S_DONE && out_free && frame_last)) begin
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[s][k] <= '0;
        end
      end
    end else if (state_r == S_READ) begin
      for (int k = 0; k < 3; k++) begin
        win_r[0][k] <= win_r[1][k];
        win_r[1][k] <= fresh[k];
      end
    end
  end

  // Line memory: upper line in the high half, middle line in the low half.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= line_mem[c_eff[AW-1:0]];
    end
    if (state_r == S_READ) begin
      line_mem[cur_col_r[AW-1:0]] <= {fresh[1], fresh[2]};
    end
  end

  always_ff @(posedge clk) begin
    total_r <= prod[EW-1:0];
    if (in_acc) begin
      cur_col_r    <= c_eff;
      item_flush_r <= in_tuser;
      item_pix_r   <= pixel_t'(in_tdata);
    end
    for (int l = 0; l < NUM_CH; l++) begin
      if (state_r == S_READ) begin
        grad_r[l] <= grad_nxt[l];
      end
      if (state_r == S_SQR) begin
        rad_r[l]  <= SQ_W'(grad_r[l].gx * grad_r[l].gx + grad_r[l].gy * grad_r[l].gy);
        rem_r[l]  <= '0;
        root_r[l] <= '0;
      end else if (state_r == S_ROOT) begin
        rad_r[l] <= {rad_r[l][SQ_W-3:0], 2'b00};
        if (rem_sh[l] >= trial[l]) begin
          rem_r[l]  <= rem_sh[l] - trial[l];
          root_r[l] <= {root_r[l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[l]  <= rem_sh[l];
          root_r[l] <= {root_r[l][ROOT_W-2:0], 1'b0};
        end
      end
    end
    if (state_r == S_DONE && out_free) begin
      out_pix_r  <= mag;
      out_last_r <= frame_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_pix_r);
  assign out_tlast  = out_last_r;

endmodule

// ===== design/sem_checker.sv =====
// Port-level checks for sobel_edge_magnitude and the bind that attaches them.
// Depends on sem_pkg and on the top level's port list.
module sem_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sem_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);
  import sem_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // A data transfer always occupies the block for at least the next cycle.
  a_busy_after_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_tuser |=> !in_tready)
    else $error("input ready right after a data transfer");

  // A new result never comes straight after an input transfer; the block is busy in between.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_xfer, 1) && !$past(in_xfer, 2))
    else $error("result appeared too soon after an input transfer");

  // Reset leaves the output channel empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (.*);
